// ----- rtl/lfrl_pkg.sv -----
// lfrl_pkg: shared types and constants for the lru/fifo replacement list
// holds the item and result payload structs, command and policy codes,
// configuration register indexes and the per-cell operation code
`default_nettype none

package lfrl_pkg;

  localparam int unsigned LINE_W  = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CFG_W   = 5;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic {
    CMD_INJECT = 1'b0,
    CMD_HIT    = 1'b1
  } cmd_t;

  typedef enum logic {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } policy_t;

  typedef enum logic {
    CFG_POLICY_MODE = 1'b0,
    CFG_CAPACITY    = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic              cmd;
    logic [LINE_W-1:0] line_entry;
    logic [POS_W-1:0]  position;
  } item_t;

  typedef struct packed {
    logic               evicted;
    logic [LINE_W-1:0]  evicted_entry;
    logic               bad_position;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/lfrl_cell.sv -----
// lfrl_cell: one storage cell of the replacement list row
// depends on lfrl_pkg for the cell operation code
`default_nettype none

module lfrl_cell #(
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire lfrl_pkg::cell_op_t     op,
  input  wire logic [ENTRY_WIDTH-1:0] left_value,
  input  wire logic [ENTRY_WIDTH-1:0] right_value,
  input  wire logic [ENTRY_WIDTH-1:0] load_value,
  output logic      [ENTRY_WIDTH-1:0] value
);
  import lfrl_pkg::*;

  logic [ENTRY_WIDTH-1:0] value_next;

  always_comb begin
    case (op)
      CELL_HOLD:       value_next = value;
      CELL_FROM_LEFT:  value_next = left_value;
      CELL_FROM_RIGHT: value_next = right_value;
      CELL_LOAD:       value_next = load_value;
      default:         value_next = value;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// ----- rtl/lru_fifo_replacement_list.sv -----
// lru_fifo_replacement_list: bounded replacement list as a row of shifting cells
// result: registered from the accepted transaction, valid in the cycle after it is accepted
// throughput: one transaction per cycle while the result is not stalled, since every cell shifts or loads in parallel
// reset: clears the entry count, the configuration registers and the result valid; entry contents
// stay undefined until written and are never used before that
// depends on lfrl_pkg and lfrl_cell
`default_nettype none

module lru_fifo_replacement_list #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire lfrl_pkg::item_t               item,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output lfrl_pkg::result_t                  result,
  input  wire logic                          cfg_we,
  input  wire lfrl_pkg::cfg_index_t          cfg_index,
  input  wire logic [lfrl_pkg::CFG_W-1:0]    cfg_data
);
  import lfrl_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PCMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned CCMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // configuration
  policy_t            policy_mode;
  logic [COUNT_W-1:0] capacity;

  // list control
  logic [CNT_W-1:0]       held_count;
  logic [CNT_W-1:0]       count_next;
  logic [CCMP_W-1:0]      eff_capacity;
  logic                   accept;
  logic                   is_inject;
  logic                   full;
  logic                   pos_ok;
  logic [IDX_W-1:0]       read_idx;
  logic [ENTRY_WIDTH-1:0] read_value;
  logic [ENTRY_WIDTH-1:0] load_value;
  result_t                result_next;

  cell_op_t               cell_op [DEPTH];
  logic [ENTRY_WIDTH-1:0] cell_value [DEPTH];

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign is_inject  = (item.cmd == CMD_INJECT);

  always_comb begin
    if (capacity == '0) begin
      eff_capacity = CCMP_W'(1);
    end else if (CCMP_W'(capacity) > CCMP_W'(DEPTH)) begin
      eff_capacity = CCMP_W'(DEPTH);
    end else begin
      eff_capacity = CCMP_W'(capacity);
    end
  end

  assign full   = CCMP_W'(held_count) >= eff_capacity;
  assign pos_ok = PCMP_W'(item.position) < PCMP_W'(held_count);

  // one read port over the row: hit entry, or the entry falling off the list (the back under LRU, cell zero under FIFO)
  always_comb begin
    if (!is_inject) begin
      read_idx = IDX_W'(item.position);
    end else if (policy_mode == POLICY_LRU) begin
      read_idx = IDX_W'(held_count - CNT_W'(1));
    end else begin
      read_idx = '0;
    end
  end

  assign read_value = cell_value[read_idx];
  assign load_value = is_inject ? ENTRY_WIDTH'(item.line_entry) : read_value;
  assign count_next = (is_inject && !full) ? held_count + CNT_W'(1) : held_count;

  // per-cell operation for this transaction
  always_comb begin
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] top;
    for (int i = 0; i < DEPTH; i++) begin
      idx        = CNT_W'(i);
      top        = '0;
      cell_op[i] = CELL_HOLD;
      if (accept && (is_inject || pos_ok)) begin
        if (policy_mode == POLICY_LRU) begin
          // shift toward the back up to the vacated slot, new front at cell zero
          if (is_inject) begin
            top = full ? held_count - CNT_W'(1) : held_count;
          end else begin
            top = CNT_W'(item.position);
          end
          if (idx == '0) begin
            cell_op[i] = CELL_LOAD;
          end else if (idx <= top) begin
            cell_op[i] = CELL_FROM_LEFT;
          end
        end else begin
          if (is_inject && !full) begin
            if (idx == held_count) begin
              cell_op[i] = CELL_LOAD;
            end
          end else begin
            // close the gap toward the front, new back at the last held cell
            if (idx == held_count - CNT_W'(1)) begin
              cell_op[i] = CELL_LOAD;
            end else if (idx < held_count - CNT_W'(1) &&
                         (is_inject || idx >= CNT_W'(item.position))) begin
              cell_op[i] = CELL_FROM_RIGHT;
            end
          end
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_value;
    logic [ENTRY_WIDTH-1:0] right_value;
    if (g > 0) begin : g_left
      assign left_value = cell_value[g-1];
    end else begin : g_left_edge
      assign left_value = '0;
    end
    if (g < DEPTH - 1) begin : g_right
      assign right_value = cell_value[g+1];
    end else begin : g_right_edge
      assign right_value = '0;
    end
    lfrl_cell #(
      .ENTRY_WIDTH(ENTRY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .left_value (left_value),
      .right_value(right_value),
      .load_value (load_value),
      .value      (cell_value[g])
    );
  end

  always_comb begin
    result_next.evicted       = is_inject && full;
    result_next.evicted_entry = (is_inject && full) ? LINE_W'(read_value) : '0;
    result_next.bad_position  = !is_inject && !pos_ok;
    result_next.entry_count   = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode  <= POLICY_LRU;
      capacity     <= CAPACITY_RESET;
      held_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY_MODE: policy_mode <= policy_t'(cfg_data[0]);
          CFG_CAPACITY:    capacity    <= cfg_data;
          default:         ;
        endcase
      end
      if (accept) begin
        held_count   <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(held_count) <= CNT_W'(DEPTH))
    else $error("entry count beyond list depth");

  a_count_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(held_count))
    else $error("entry count changed without a transaction");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted transaction produced no result");

  a_evict_excludes_bad: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.evicted && result.bad_position))
    else $error("result flags both eviction and bad position");

  a_count_matches_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.entry_count == COUNT_W'(held_count))
    else $error("reported entry count differs from held count");

endmodule

`default_nettype wire
